>>> hw/rtl/u8sd_pkg.sv
package u8sd_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int SURR_W = 10;

    // Lead byte patterns and masks
    localparam logic [7:0] MASK_E0  = 8'hE0;
    localparam logic [7:0] MASK_F0  = 8'hF0;
    localparam logic [7:0] MASK_F8  = 8'hF8;
    localparam logic [7:0] MASK_C0  = 8'hC0;
    localparam logic [7:0] LEAD2    = 8'hC0;
    localparam logic [7:0] LEAD3    = 8'hE0;
    localparam logic [7:0] LEAD4    = 8'hF0;
    localparam logic [7:0] CONT_PAT = 8'h80;

    // Surrogate ranges and join offset
    localparam logic [CP_W-1:0] HI_SURR_MIN = 21'h00D800;
    localparam logic [CP_W-1:0] HI_SURR_MAX = 21'h00DBFF;
    localparam logic [CP_W-1:0] LO_SURR_MIN = 21'h00DC00;
    localparam logic [CP_W-1:0] LO_SURR_MAX = 21'h00DFFF;
    localparam logic [CP_W-1:0] SURR_BASE   = 21'h010000;

    // Byte classes decided by the front end
    typedef enum logic [2:0] {
        K_END   = 3'd0,
        K_ZERO  = 3'd1,
        K_ASCII = 3'd2,
        K_LEAD2 = 3'd3,
        K_LEAD3 = 3'd4,
        K_LEAD4 = 3'd5,
        K_CONT  = 3'd6,
        K_SKIP  = 3'd7
    } t_kind;

    // One classified item in the queue
    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
    } t_token;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> hw/rtl/u8sd_if.sv
interface u8sd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface u8sd_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        stream_ended;

    modport source (output valid, output code_point, output stream_ended, input ready);
    modport sink   (input valid, input code_point, input stream_ended, output ready);
endinterface

>>> hw/rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder. One byte (or an end marker) is taken per item and
// at most one decoded code point comes out per item, with a steady rate of
// one item per clock when the output is not stalled. A front end classifies
// each byte and pushes it into a small queue (QUEUE_DEPTH entries); the back
// end pops one item per cycle unless stalled, updates the decode and
// surrogate state and loads the output register. An item passes the queue,
// then the output register. Skipped bytes, lead and non-final continuation
// bytes and high surrogates produce no output item. A zero byte or an end
// marker clears all state and emits code point 0 (stream_ended set for end).
module utf8_stream_decoder
    import u8sd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    u8sd_in_if.sink           i_in,
    u8sd_out_if.source        o_out
);

    t_q_status q_status;
    logic      push;
    logic      pop;
    t_token    push_token;
    t_token    pop_token;

    u8sd_front u_front (
        .i_valid         (i_in.valid),
        .i_data_byte     (i_in.data_byte),
        .i_end_of_stream (i_in.end_of_stream),
        .o_ready         (i_in.ready),
        .i_q_status      (q_status),
        .o_push          (push),
        .o_token         (push_token)
    );

    u8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_token  (push_token),
        .i_pop    (pop),
        .o_token  (pop_token),
        .o_status (q_status)
    );

    u8sd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_token        (pop_token),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_code_point   (o_out.code_point),
        .o_stream_ended (o_out.stream_ended)
    );

endmodule

>>> hw/rtl/u8sd_front.sv
module u8sd_front
    import u8sd_pkg::*;
(
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_end_of_stream,
    output logic              o_ready,
    input  t_q_status         i_q_status,
    output logic              o_push,
    output t_token            o_token
);

    // Accept whenever the queue has room
    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    // Classify the byte
    always_comb begin
        o_token.data = i_data_byte;
        if (i_end_of_stream) begin
            o_token.kind = K_END;
        end else if (i_data_byte == '0) begin
            o_token.kind = K_ZERO;
        end else if (!i_data_byte[7]) begin
            o_token.kind = K_ASCII;
        end else if ((i_data_byte & MASK_C0) == CONT_PAT) begin
            o_token.kind = K_CONT;
        end else if ((i_data_byte & MASK_E0) == LEAD2) begin
            o_token.kind = K_LEAD2;
        end else if ((i_data_byte & MASK_F0) == LEAD3) begin
            o_token.kind = K_LEAD3;
        end else if ((i_data_byte & MASK_F8) == LEAD4) begin
            o_token.kind = K_LEAD4;
        end else begin
            o_token.kind = K_SKIP;
        end
    end

endmodule

>>> hw/rtl/u8sd_queue.sv
module u8sd_queue
    import u8sd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_token    i_token,
    input  logic      i_pop,
    output t_token    o_token,
    output t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_token           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign o_token        = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

endmodule

>>> hw/rtl/u8sd_back.sv
module u8sd_back
    import u8sd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_token          i_token,
    input  t_q_status       i_q_status,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [CP_W-1:0] o_code_point,
    output logic            o_stream_ended
);

    logic [CP_W-1:0]   r_partial, n_partial;
    logic [1:0]        r_remain, n_remain;
    logic [SURR_W-1:0] r_held, n_held;
    logic              r_held_vld, n_held_vld;
    logic              r_out_vld;
    logic [CP_W-1:0]   r_cp, n_cp;
    logic              r_ended, n_ended;
    logic              emit;
    logic              finish;
    logic [CP_W-1:0]   fin_val;
    logic [CP_W-1:0]   acc_val;

    // Take the next item when the output register is free or drains now
    assign o_pop = !i_q_status.empty && (!r_out_vld || i_ready);

    assign acc_val = {r_partial[CP_W-7:0], i_token.data[5:0]};

    // Decode step
    always_comb begin
        n_partial  = r_partial;
        n_remain   = r_remain;
        n_held     = r_held;
        n_held_vld = r_held_vld;
        n_cp       = '0;
        n_ended    = 1'b0;
        emit       = 1'b0;
        finish     = 1'b0;
        fin_val    = '0;

        if (i_token.kind == K_END || i_token.kind == K_ZERO) begin
            n_partial  = '0;
            n_remain   = '0;
            n_held     = '0;
            n_held_vld = 1'b0;
            emit       = 1'b1;
            n_ended    = (i_token.kind == K_END);
        end else if (r_remain != '0 && i_token.kind == K_CONT) begin
            n_remain = r_remain - 1'b1;
            if (r_remain == 2'd1) begin
                n_partial = '0;
                finish    = 1'b1;
                fin_val   = acc_val;
            end else begin
                n_partial = acc_val;
            end
        end else begin
            // No open sequence, or one interrupted by this byte
            n_partial = '0;
            n_remain  = '0;
            case (i_token.kind)
                K_ASCII: begin
                    finish  = 1'b1;
                    fin_val = CP_W'(i_token.data);
                end
                K_LEAD2: begin
                    n_partial = CP_W'(i_token.data[4:0]);
                    n_remain  = 2'd1;
                end
                K_LEAD3: begin
                    n_partial = CP_W'(i_token.data[3:0]);
                    n_remain  = 2'd2;
                end
                K_LEAD4: begin
                    n_partial = CP_W'(i_token.data[2:0]);
                    n_remain  = 2'd3;
                end
                default: begin
                end
            endcase
        end

        // Surrogate pairing on a completed value
        if (finish) begin
            if (r_held_vld && fin_val >= LO_SURR_MIN && fin_val <= LO_SURR_MAX) begin
                n_cp       = CP_W'({r_held, fin_val[SURR_W-1:0]}) + SURR_BASE;
                n_held     = '0;
                n_held_vld = 1'b0;
                emit       = 1'b1;
            end else if (fin_val >= HI_SURR_MIN && fin_val <= HI_SURR_MAX) begin
                n_held     = fin_val[SURR_W-1:0];
                n_held_vld = 1'b1;
            end else begin
                n_cp       = fin_val;
                n_held     = '0;
                n_held_vld = 1'b0;
                emit       = 1'b1;
            end
        end
    end

    // Decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial  <= '0;
            r_remain   <= '0;
            r_held     <= '0;
            r_held_vld <= 1'b0;
        end else if (o_pop) begin
            r_partial  <= n_partial;
            r_remain   <= n_remain;
            r_held     <= n_held;
            r_held_vld <= n_held_vld;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_pop) begin
            r_out_vld <= emit;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_cp    <= n_cp;
            r_ended <= n_ended;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_code_point   = r_cp;
    assign o_stream_ended = r_ended;

endmodule

>>> hw/rtl/u8sd_checker.sv
module u8sd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [20:0] i_out_code_point,
    input logic        i_out_stream_ended
);

    // Nothing comes out right after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // Empty queue takes input right after reset
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    // An end report carries code point zero
    a_end_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stream_ended) |-> (i_out_code_point == '0))
        else $error("end report with nonzero code point");

    // Stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_code_point) && $stable(i_out_stream_ended)))
        else $error("stalled output item changed");

endmodule

bind utf8_stream_decoder u8sd_checker u_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_code_point   (o_out.code_point),
    .i_out_stream_ended (o_out.stream_ended)
);

>>> tb/utf8_stream_decoder_tb.sv
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;
    import u8sd_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 16;

    // One byte item as driven, plus a flag that makes the sender wait for all results
    typedef struct packed {
        logic              drain_first;
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_stream;
    } t_stream_item;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            stream_ended;
    } t_cp_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    u8sd_in_if  in_if ();
    u8sd_out_if out_if ();

    utf8_stream_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #4 i_clk = ~i_clk;

    t_stream_item pending_bytes[$];
    t_cp_result   expected_cps[$];

    int  total_items    = 0;
    int  items_accepted = 0;
    int  results_seen   = 0;
    int  fail_count     = 0;
    int  pairs_joined   = 0;
    int  ends_reported  = 0;
    int  send_gap       = 0;
    int  recv_gap       = 0;
    bit  byte_taken     = 1'b0;
    bit  drain_next     = 1'b0;

    // Decoder state mirrored by the predictor
    logic [CP_W-1:0]   dec_partial;
    logic [1:0]        dec_remaining;
    logic [SURR_W-1:0] held_hi;
    logic              held_valid;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Completed value: join with a held high surrogate, hold a new one, or emit
    task automatic settle_value(input logic [CP_W-1:0] v);
        t_cp_result r;
        r.stream_ended = 1'b0;
        if (held_valid && v >= LO_SURR_MIN && v <= LO_SURR_MAX) begin
            r.code_point = {1'b0, held_hi, v[9:0]} + SURR_BASE;
            held_valid   = 1'b0;
            held_hi      = '0;
            pairs_joined++;
            expected_cps.push_back(r);
        end else if (v >= HI_SURR_MIN && v <= HI_SURR_MAX) begin
            held_hi    = v[SURR_W-1:0];
            held_valid = 1'b1;
        end else begin
            held_valid   = 1'b0;
            held_hi      = '0;
            r.code_point = v;
            expected_cps.push_back(r);
        end
    endtask

    // Nonzero byte with no sequence open
    task automatic open_byte(input logic [7:0] b);
        if (!b[7]) begin
            settle_value({13'b0, b});
        end else if ((b & MASK_E0) == LEAD2) begin
            dec_partial   = {16'b0, b[4:0]};
            dec_remaining = 2'd1;
        end else if ((b & MASK_F0) == LEAD3) begin
            dec_partial   = {17'b0, b[3:0]};
            dec_remaining = 2'd2;
        end else if ((b & MASK_F8) == LEAD4) begin
            dec_partial   = {18'b0, b[2:0]};
            dec_remaining = 2'd3;
        end
        // stray continuation and F8-FF fall through untouched
    endtask

    task automatic decode_item(input t_stream_item it);
        logic [7:0]      b;
        logic [CP_W-1:0] v;
        t_cp_result      r;
        b = it.data_byte;
        if (it.end_of_stream || b == 8'h00) begin
            dec_partial    = '0;
            dec_remaining  = '0;
            held_hi        = '0;
            held_valid     = 1'b0;
            r.code_point   = '0;
            r.stream_ended = it.end_of_stream;
            if (it.end_of_stream) ends_reported++;
            expected_cps.push_back(r);
        end else if (dec_remaining == 2'd0) begin
            open_byte(b);
        end else if ((b & MASK_C0) == CONT_PAT) begin
            dec_partial   = {dec_partial[CP_W-7:0], b[5:0]};
            dec_remaining = dec_remaining - 2'd1;
            if (dec_remaining == 2'd0) begin
                v           = dec_partial;
                dec_partial = '0;
                settle_value(v);
            end
        end else begin
            // interrupted sequence: drop partial, treat byte as fresh
            dec_partial   = '0;
            dec_remaining = '0;
            open_byte(b);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_byte(input logic [7:0] b, input logic eos);
        t_stream_item it;
        it.drain_first   = drain_next;
        it.data_byte     = b;
        it.end_of_stream = eos;
        drain_next       = 1'b0;
        pending_bytes.push_back(it);
    endtask

    // Encode v in len bytes, first byte in the top lane
    function automatic logic [31:0] utf8_bytes(input logic [CP_W-1:0] v, input int len);
        case (len)
            1:       utf8_bytes = {1'b0, v[6:0], 24'b0};
            2:       utf8_bytes = {3'b110, v[10:6], 2'b10, v[5:0], 16'b0};
            3:       utf8_bytes = {4'b1110, v[15:12], 2'b10, v[11:6], 2'b10, v[5:0], 8'b0};
            default: utf8_bytes = {5'b11110, v[20:18], 2'b10, v[17:12],
                                   2'b10, v[11:6], 2'b10, v[5:0]};
        endcase
    endfunction

    function automatic int utf8_len(input logic [CP_W-1:0] v);
        if (v < 21'h80)         utf8_len = 1;
        else if (v < 21'h800)   utf8_len = 2;
        else if (v < 21'h10000) utf8_len = 3;
        else                    utf8_len = 4;
    endfunction

    // Push the first count bytes of a len-byte encoding
    task automatic push_seq(input logic [CP_W-1:0] v, input int len, input int count);
        logic [31:0] seq;
        seq = utf8_bytes(v, len);
        for (int i = 0; i < count; i++) begin
            push_byte(seq[31:24], 1'b0);
            seq = seq << 8;
        end
    endtask

    task automatic push_cp(input logic [CP_W-1:0] v);
        push_seq(v, utf8_len(v), utf8_len(v));
    endtask

    task automatic push_random_sequence();
        int              kind;
        int              len;
        logic [CP_W-1:0] v;
        logic [7:0]      b;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            push_cp(CP_W'($urandom_range(1, 21'h7F)));
        end else if (kind < 40) begin
            push_cp(CP_W'($urandom_range(21'h80, 21'h7FF)));
        end else if (kind < 55) begin
            push_cp(CP_W'($urandom_range(21'h800, 21'hFFFF)));
        end else if (kind < 65) begin
            push_cp(CP_W'($urandom_range(21'h10000, 21'h1FFFFF)));
        end else if (kind < 75) begin
            // well-formed surrogate pair
            push_cp(HI_SURR_MIN + CP_W'($urandom_range(0, 10'h3FF)));
            push_cp(LO_SURR_MIN + CP_W'($urandom_range(0, 10'h3FF)));
        end else if (kind < 79) begin
            // high surrogate; whatever comes next decides its fate
            push_cp(HI_SURR_MIN + CP_W'($urandom_range(0, 10'h3FF)));
        end else if (kind < 81) begin
            push_cp(LO_SURR_MIN + CP_W'($urandom_range(0, 10'h3FF)));
        end else if (kind < 84) begin
            // overlong form of a short value
            v   = CP_W'($urandom_range(0, 21'h7FF));
            len = $urandom_range(utf8_len(v) + 1 > 4 ? 4 : utf8_len(v) + 1, 4);
            push_seq(v, len, len);
        end else if (kind < 89) begin
            // truncated sequence broken by a non-continuation byte
            len = $urandom_range(2, 4);
            push_seq(CP_W'($urandom_range(0, 21'h1FFFFF)), len, $urandom_range(1, len - 1));
            b = 8'($urandom_range(0, 255));
            if (b[7:6] == 2'b10) b[6] = 1'b1;
            push_byte(b, 1'b0);
        end else if (kind < 93) begin
            push_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (kind < 95) begin
            push_byte(8'h00, 1'b0);
        end else if (kind < 97) begin
            push_byte(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            if ($urandom_range(0, 1)) push_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
            else                      push_byte(8'($urandom_range(8'hF8, 8'hFF)), 1'b0);
        end
    endtask

    // Mostly short gaps, a few long ones, and every third hundred items none
    function automatic int pick_gap();
        int r;
        if ((items_accepted / 100) % 3 == 2) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: inputs change on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        t_stream_item nxt;
        if (!i_rst_n) begin
            in_if.valid  <= 1'b0;
            out_if.ready <= 1'b0;
        end else begin
            // sender side: hold an item until taken
            if (!(in_if.valid && !byte_taken)) begin
                byte_taken = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_bytes.size() > 0 &&
                             !(pending_bytes[0].drain_first && expected_cps.size() != 0)) begin
                    nxt = pending_bytes.pop_front();
                    in_if.valid         <= 1'b1;
                    in_if.data_byte     <= nxt.data_byte;
                    in_if.end_of_stream <= nxt.end_of_stream;
                    send_gap = pick_gap();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end

            // receiver side: random stalls
            if (recv_gap > 0) begin
                recv_gap--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: results checked, accepted bytes predicted on the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_cp_result   want;
        t_stream_item took;
        if (i_rst_n) begin
            // results first: one arriving now belongs to an earlier byte
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                if (expected_cps.size() == 0) begin
                    $error("unexpected item: code_point %h stream_ended %b",
                           out_if.code_point, out_if.stream_ended);
                    fail_count++;
                end else begin
                    want = expected_cps.pop_front();
                    if (out_if.code_point !== want.code_point) begin
                        $error("code_point: expected %h, actual %h",
                               want.code_point, out_if.code_point);
                        fail_count++;
                    end
                    if (out_if.stream_ended !== want.stream_ended) begin
                        $error("stream_ended: expected %b, actual %b",
                               want.stream_ended, out_if.stream_ended);
                        fail_count++;
                    end
                end
            end

            if (in_if.valid && in_if.ready) begin
                took.drain_first   = 1'b0;
                took.data_byte     = in_if.data_byte;
                took.end_of_stream = in_if.end_of_stream;
                decode_item(took);
                byte_taken = 1'b1;
                items_accepted++;
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin : watchdog
        int idle_cycles;
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout after %0d idle cycles", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        in_if.valid         = 1'b0;
        in_if.data_byte     = 8'h00;
        in_if.end_of_stream = 1'b0;
        out_if.ready        = 1'b0;
        dec_partial         = '0;
        dec_remaining       = '0;
        held_hi             = '0;
        held_valid          = 1'b0;

        // Directed: field extremes, every length, pair join, skips, breaks, end
        push_byte(8'h00, 1'b0);           // zero byte
        push_byte(8'h7F, 1'b0);           // largest ASCII
        push_cp(21'h7FF);                 // DF BF
        push_cp(21'hFFFF);                // EF BF BF
        push_seq(21'h1FFFFF, 4, 4);       // F7 BF BF BF, above 10FFFF
        push_cp(HI_SURR_MIN);             // held
        push_cp(LO_SURR_MIN);             // joins to 10000
        push_byte(8'h80, 1'b0);           // stray continuation
        push_byte(8'hFF, 1'b0);           // skipped byte
        push_byte(8'hE2, 1'b0);           // lead, then interrupted by ASCII
        push_byte(8'h41, 1'b0);
        push_cp(HI_SURR_MAX);             // held, then cleared by end
        push_byte(8'hFF, 1'b1);           // end marker, byte ignored

        // Random: mostly valid text, some noise; drains first, maybe again near 400
        drain_next = 1'b1;
        while (pending_bytes.size() < RANDOM_ITEMS + 25) begin
            if (pending_bytes.size() >= 400 && pending_bytes.size() < 404) drain_next = 1'b1;
            push_random_sequence();
        end
        push_byte(8'h00, 1'b1);
        total_items = pending_bytes.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (items_accepted < total_items) @(negedge i_clk);
        while (expected_cps.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Sent %0d byte items, checked %0d code point items", items_accepted,
                 results_seen);
        $display("Covered %0d surrogate joins and %0d end markers", pairs_joined,
                 ends_reported);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/u8sd_pkg.sv
hw/rtl/u8sd_if.sv
hw/rtl/u8sd_front.sv
hw/rtl/u8sd_queue.sv
hw/rtl/u8sd_back.sv
hw/rtl/utf8_stream_decoder.sv
hw/rtl/u8sd_checker.sv
tb/utf8_stream_decoder_tb.sv
